// ===== src/rna_pkg.sv =====
// rna_pkg: commands, status codes, sequencer states and the command struct
// passed from the sequencer to the serial units. no dependencies.
package rna_pkg;

   localparam int unsigned WordWidth = 64;
   localparam int unsigned CntWidth  = 7;

   typedef logic [WordWidth-1:0] word_type;
   typedef logic [CntWidth-1:0]  count_type;

   typedef enum logic [3:0] {
      CMD_ADD    = 4'd0,
      CMD_SUB    = 4'd1,
      CMD_MUL    = 4'd2,
      CMD_DIV    = 4'd3,
      CMD_NEG    = 4'd4,
      CMD_INV    = 4'd5,
      CMD_CMP    = 4'd6,
      CMD_EQU    = 4'd7,
      CMD_RED    = 4'd8
   } cmd_type;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DEG  = 2'd1;
   localparam logic [1:0] ST_INVZ = 2'd2;

   // serial unit operations
   typedef enum logic [1:0] {
      OP_MUL = 2'd0,
      OP_DIV = 2'd1
   } op_type;

   typedef struct packed {
      logic   go;
      op_type op;
   } unit_ctl_type;

   typedef struct packed {
      logic done;
   } unit_sts_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_M1, S_M1W, S_M2, S_M2W,      // two cross products
      S_M3, S_M3W,                   // product of the denominators
      S_XFORM,                       // add/sub/compare/ready operands
      S_G1, S_G1W,                   // gcd step: x mod y
      S_G1N,
      S_Q1, S_Q1W,                   // divide by gcd
      S_Q2, S_Q2W,
      S_Q3, S_Q3W,
      S_Q4, S_Q4W,
      S_P1, S_P1W,                   // product of quotients
      S_P2, S_P2W,
      S_RED,
      S_DONE
   } state_type;

   function automatic word_type mag(input word_type n);
      return n[WordWidth-1] ? (~n + 1'b1) : n;
   endfunction

endpackage

// ===== src/rna_serial.sv =====
// rna_serial: bit-serial 64-bit wrapping multiplier and restoring divider.
// depends on rna_pkg.
module rna_serial
   import rna_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  unit_ctl_type ctl,
   input  word_type     opa,
   input  word_type     opb,
   output word_type     res_lo,
   output word_type     res_hi,
   output unit_sts_type sts
);

   op_type    op_ff, op_in;
   logic      busy_ff, busy_in;
   logic      done_ff, done_in;
   count_type cnt_ff, cnt_in;
   word_type  acc_ff, acc_in;   // product or remainder
   word_type  sa_ff, sa_in;     // shifting multiplicand or dividend/quotient
   word_type  sb_ff, sb_in;     // multiplier or divisor
   logic [WordWidth:0] trial;

   always_comb begin
      op_in   = op_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      sa_in   = sa_ff;
      sb_in   = sb_ff;
      trial   = '0;
      if (ctl.go) begin
         op_in   = ctl.op;
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         sa_in   = opa;
         sb_in   = opb;
      end else if (busy_ff) begin
         case (op_ff)
            OP_MUL: begin
               // one multiplier bit per cycle
               if (sb_ff[0]) begin
                  acc_in = acc_ff + sa_ff;
               end
               sa_in = {sa_ff[WordWidth-2:0], 1'b0};
               sb_in = {1'b0, sb_ff[WordWidth-1:1]};
            end
            OP_DIV: begin
               // one quotient bit per cycle
               trial = {acc_ff, sa_ff[WordWidth-1]} - {1'b0, sb_ff};
               if (!trial[WordWidth]) begin
                  acc_in = trial[WordWidth-1:0];
                  sa_in  = {sa_ff[WordWidth-2:0], 1'b1};
               end else begin
                  acc_in = {acc_ff[WordWidth-2:0], sa_ff[WordWidth-1]};
                  sa_in  = {sa_ff[WordWidth-2:0], 1'b0};
               end
            end
            default: begin
            end
         endcase
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == count_type'(WordWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= OP_MUL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         op_ff   <= op_in;
      end
      acc_ff <= acc_in;
      sa_ff  <= sa_in;
      sb_ff  <= sb_in;
   end

   // mul: product in res_lo; div: quotient in res_lo, remainder in res_hi
   assign res_lo   = (op_ff == OP_MUL) ? acc_ff : sa_ff;
   assign res_hi   = acc_ff;
   assign sts.done = done_ff;

endmodule

// ===== src/rational_number_alu.sv =====
// rational_number_alu: top level, command sequencer around one serial unit.
// depends on rna_pkg and rna_serial.
//
//  channel  | handshake         | ports
//  request  | start & !busy     | req_cmd, req_a_num, req_a_den, req_b_num, req_b_den
//  response | rsp_valid strobe  | rsp_res_num, rsp_res_den, rsp_order, rsp_status
//
// every multiply or divide holds the shared bit-serial unit; each word first forms
// three products, all that negate, invert, compare and unused codes need; a euclid
// step is one division; reduce adds one euclid run and 2 divisions, add/sub the
// same, mul/div three runs, 8 divisions and 2 more products.
// reset is synchronous; it drops busy and clears the sequencer.
// one item at a time; the result strobe lasts one cycle and cannot be held.
module rational_number_alu
   import rna_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_cmd,
   input  logic [63:0] req_a_num,
   input  logic [63:0] req_a_den,
   input  logic [63:0] req_b_num,
   input  logic [63:0] req_b_den,
   output logic        rsp_valid,
   output logic [63:0] rsp_res_num,
   output logic [63:0] rsp_res_den,
   output logic [1:0]  rsp_order,
   output logic [1:0]  rsp_status
);

   state_type state_ff, state_in;
   logic [3:0] cmd_ff, cmd_in;
   word_type an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   word_type x_ff, x_in, y_ff, y_in;       // cross products, gcd pair
   word_type rn_ff, rn_in, rd_ff, rd_in;   // working result
   word_type g_ff, g_in;                   // gcd, denominator product before it
   logic     gphase_ff, gphase_in;         // 0: first gcd of multiply, 1: other gcds
   logic     mul_ff, mul_in;               // in multiply flow
   logic [1:0] order_ff, order_in, status_ff, status_in;
   logic     valid_ff, valid_in;

   unit_ctl_type ctl;
   unit_sts_type sts;
   word_type     uopa, uopb, ulo, uhi;

   rna_serial u_serial (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .opa    (uopa),
      .opb    (uopb),
      .res_lo (ulo),
      .res_hi (uhi),
      .sts    (sts)
   );

   logic accept;
   assign accept = start && (state_ff == S_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept) state_in = S_M1;
         S_M1:    state_in = S_M1W;
         S_M1W:   if (sts.done) state_in = S_M2;
         S_M2:    state_in = S_M2W;
         S_M2W:   if (sts.done) state_in = S_M3;
         S_M3:    state_in = S_M3W;
         S_M3W:   if (sts.done) state_in = S_XFORM;
         S_XFORM: state_in = S_G1N;
         S_G1N:   state_in = (y_ff == '0) ? S_Q1 : S_G1;
         S_G1:    state_in = S_G1W;
         S_G1W:   if (sts.done) state_in = S_G1N;
         S_Q1:    state_in = (g_ff == '0) ? S_RED : S_Q1W;
         S_Q1W:   if (sts.done) state_in = S_Q2;
         S_Q2:    state_in = S_Q2W;
         S_Q2W:   if (sts.done) state_in = S_Q3;
         S_Q3:    state_in = S_Q3W;
         S_Q3W:   if (sts.done) state_in = S_Q4;
         S_Q4:    state_in = S_Q4W;
         S_Q4W:   if (sts.done) state_in = S_P1;
         S_P1:    state_in = S_P1W;
         S_P1W:   if (sts.done) state_in = S_P2;
         S_P2:    state_in = S_P2W;
         S_P2W:   if (sts.done) state_in = S_G1N;
         S_RED:   state_in = S_DONE;
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      // early exits taken in the datapath block
      if (state_ff == S_XFORM && !gphase_in && !mul_in) state_in = S_DONE;
      if (state_ff == S_Q1 && mul_ff && !gphase_ff) state_in = S_Q1W;
      if (state_ff == S_Q2W && sts.done && mul_ff && !gphase_ff) state_in = S_G1N;
      if (state_ff == S_Q2W && sts.done && !mul_ff) state_in = S_RED;
      if (state_ff == S_Q4W && sts.done && !mul_ff) state_in = S_RED;
      if (state_ff == S_RED && mul_ff) state_in = S_DONE;
   end

   // datapath and unit control
   always_comb begin
      cmd_in = cmd_ff; an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      x_in = x_ff; y_in = y_ff; rn_in = rn_ff; rd_in = rd_ff; g_in = g_ff;
      gphase_in = gphase_ff; mul_in = mul_ff;
      order_in = order_ff; status_in = status_ff; valid_in = 1'b0;
      ctl.go = 1'b0; ctl.op = OP_MUL; uopa = '0; uopb = '0;
      case (state_ff)
         S_IDLE: if (accept) begin
            cmd_in = req_cmd; an_in = req_a_num; ad_in = req_a_den;
            bn_in = req_b_num; bd_in = req_b_den;
            rn_in = req_a_num; rd_in = req_a_den;
            order_in = 2'b00; status_in = ST_OK;
            gphase_in = 1'b0; mul_in = 1'b0;
         end
         S_M1: begin ctl.go = 1'b1; ctl.op = OP_MUL; uopa = an_ff; uopb = bd_ff; end
         S_M1W: if (sts.done) x_in = ulo;
         S_M2: begin ctl.go = 1'b1; ctl.op = OP_MUL; uopa = ad_ff; uopb = bn_ff; end
         S_M2W: if (sts.done) y_in = ulo;
         S_M3: begin ctl.go = 1'b1; ctl.op = OP_MUL; uopa = ad_ff; uopb = bd_ff; end
         S_M3W: if (sts.done) g_in = ulo;
         S_XFORM: begin
            // gphase_in: go to gcd reduction of rn/rd; mul_in: multiply flow
            gphase_in = 1'b0;
            case (cmd_ff)
               CMD_ADD, CMD_SUB: begin
                  if (ad_ff == '0 || bd_ff == '0) status_in = ST_DEG;
                  else begin
                     rn_in = (cmd_ff == CMD_ADD) ? x_ff + y_ff : x_ff - y_ff;
                     rd_in = g_ff;
                     gphase_in = 1'b1;
                     x_in = mag(rn_in); y_in = rd_in;
                  end
               end
               CMD_MUL, CMD_DIV: begin
                  if (ad_ff == '0 || bd_ff == '0) status_in = ST_DEG;
                  else if (cmd_ff == CMD_DIV && bn_ff == '0) begin
                     rn_in = 64'd1 ^ 64'd1; rd_in = 64'd1; status_in = ST_INVZ;
                  end else begin
                     if (cmd_ff == CMD_DIV) begin
                        bn_in = bn_ff[63] ? (~bd_ff + 1'b1) : bd_ff;
                        bd_in = mag(bn_ff);
                     end
                     mul_in = 1'b1;
                     x_in = mag(bn_in); y_in = ad_ff;
                  end
               end
               CMD_NEG: begin
                  if (ad_ff == '0) status_in = ST_DEG;
                  else rn_in = ~an_ff + 1'b1;
               end
               CMD_INV: begin
                  if (ad_ff == '0) status_in = ST_DEG;
                  else if (an_ff == '0) status_in = ST_INVZ;
                  else begin
                     rn_in = an_ff[63] ? (~ad_ff + 1'b1) : ad_ff;
                     rd_in = mag(an_ff);
                  end
               end
               CMD_CMP, CMD_EQU: begin
                  if (cmd_ff == CMD_CMP)
                     order_in = (x_ff == y_ff) ? 2'b00 :
                                ((x_ff - y_ff) >> 63 != 0) ? 2'b11 : 2'b01;
                  else order_in = (x_ff == y_ff) ? 2'b01 : 2'b00;
                  if (ad_ff == '0 || bd_ff == '0) status_in = ST_DEG;
               end
               CMD_RED: begin
                  if (ad_ff == '0) status_in = ST_DEG;
                  else begin
                     gphase_in = 1'b1;
                     x_in = mag(an_ff); y_in = ad_ff;
                  end
               end
               default: begin
               end
            endcase
         end
         S_G1: begin ctl.go = 1'b1; ctl.op = OP_DIV; uopa = x_ff; uopb = y_ff; end
         S_G1W: if (sts.done) begin x_in = y_ff; y_in = uhi; end
         S_G1N: if (y_ff == '0) g_in = x_ff;
         S_Q1: begin
            // first gcd of the multiply: divide b_num; otherwise divide rn
            ctl.go = (g_ff != '0); ctl.op = OP_DIV;
            if (mul_ff && !gphase_ff) uopa = mag(bn_ff);
            else uopa = mag(rn_ff);
            uopb = g_ff;
         end
         S_Q1W: if (sts.done) begin
            if (mul_ff && !gphase_ff) bn_in = bn_ff[63] ? (~ulo + 1'b1) : ulo;
            else rn_in = rn_ff[63] ? (~ulo + 1'b1) : ulo;
         end
         S_Q2: begin
            ctl.go = 1'b1; ctl.op = OP_DIV; uopb = g_ff;
            uopa = (mul_ff && !gphase_ff) ? ad_ff : rd_ff;
         end
         S_Q2W: if (sts.done) begin
            if (mul_ff && !gphase_ff) begin
               ad_in = ulo; gphase_in = 1'b1;
               x_in = mag(an_ff); y_in = bd_ff;
            end else rd_in = ulo;
         end
         S_Q3: begin ctl.go = 1'b1; ctl.op = OP_DIV; uopa = mag(an_ff); uopb = g_ff; end
         S_Q3W: if (sts.done) an_in = an_ff[63] ? (~ulo + 1'b1) : ulo;
         S_Q4: begin ctl.go = 1'b1; ctl.op = OP_DIV; uopa = bd_ff; uopb = g_ff; end
         S_Q4W: if (sts.done) bd_in = ulo;
         S_P1: begin ctl.go = 1'b1; ctl.op = OP_MUL; uopa = an_ff; uopb = bn_ff; end
         S_P1W: if (sts.done) rn_in = ulo;
         S_P2: begin ctl.go = 1'b1; ctl.op = OP_MUL; uopa = ad_ff; uopb = bd_ff; end
         S_P2W: if (sts.done) begin
            rd_in = ulo; mul_in = 1'b0;
            x_in = mag(rn_ff); y_in = ulo;
         end
         S_RED: begin
            if ((cmd_ff <= CMD_DIV) && status_ff == ST_OK && rd_ff == '0) status_in = ST_DEG;
         end
         S_DONE: valid_in = 1'b1;
         default: begin
         end
      endcase
      if (state_ff == S_XFORM && cmd_ff <= CMD_DIV && status_in == ST_OK && !mul_in
          && rd_in == '0 && !gphase_in) status_in = ST_DEG;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in; an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      x_ff <= x_in; y_ff <= y_in; rn_ff <= rn_in; rd_ff <= rd_in; g_ff <= g_in;
      gphase_ff <= gphase_in; mul_ff <= mul_in;
      order_ff <= order_in; status_ff <= status_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = valid_ff;
   assign rsp_res_num = rn_ff;
   assign rsp_res_den = rd_ff;
   assign rsp_order   = order_ff;
   assign rsp_status  = status_ff;

endmodule

// ===== test/tb.sv =====
// tb: self-checking bench for rational_number_alu, random and directed commands
// checked against an in-bench rational arithmetic predictor. depends on rna_pkg and rational_number_alu.
module tb;
   import rna_pkg::*;

   typedef struct {
      logic [3:0]  cmd;
      logic [63:0] an, ad, bn, bd;
   } req_word_type;

   typedef struct {
      logic [63:0] num, den;
      logic [1:0]  order, status;
   } rsp_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [3:0]  req_cmd = '0;
   logic [63:0] req_a_num = '0, req_a_den = '0, req_b_num = '0, req_b_den = '0;
   logic        rsp_valid;
   logic [63:0] rsp_res_num, rsp_res_den;
   logic [1:0]  rsp_order, rsp_status;

   req_word_type pending_q[$];
   rsp_word_type expected_q[$];
   int          idle_pct = 24;
   int          errors = 0;
   int          n_sent = 0;
   int          n_checked = 0;
   bit          stim_done = 1'b0;

   rational_number_alu u_dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [63:0] gcd_u(logic [63:0] x, logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic logic [63:0] abs_u(logic [63:0] n);
      return n[63] ? -n : n;
   endfunction

   function automatic logic [63:0] sdiv_u(logic [63:0] n, logic [63:0] g);
      logic [63:0] q;
      q = abs_u(n) / g;
      return n[63] ? -q : q;
   endfunction

   function automatic void lowest_terms(inout logic [63:0] n, inout logic [63:0] d);
      logic [63:0] g;
      g = gcd_u(abs_u(n), d);
      if (g != 0) begin
         n = sdiv_u(n, g);
         d = d / g;
      end
   endfunction

   function automatic void rat_mul(inout logic [63:0] n1, inout logic [63:0] d1,
                                   input logic [63:0] n2, input logic [63:0] d2);
      logic [63:0] g1, g2, bn, ad, an, bd;
      g1 = gcd_u(abs_u(n2), d1);
      g2 = gcd_u(abs_u(n1), d2);
      bn = sdiv_u(n2, g1);
      ad = d1 / g1;
      an = sdiv_u(n1, g2);
      bd = d2 / g2;
      n1 = an * bn;
      d1 = ad * bd;
      lowest_terms(n1, d1);
   endfunction

   function automatic rsp_word_type rational_result(req_word_type r);
      rsp_word_type o;
      logic [63:0] x, y, rn, rd;
      logic        adeg, bdeg;
      rn = r.an;
      rd = r.ad;
      o.order = 2'b00;
      o.status = ST_OK;
      adeg = (r.ad == 0);
      bdeg = (r.bd == 0);
      case (r.cmd)
         CMD_ADD, CMD_SUB: begin
            if (adeg || bdeg) o.status = ST_DEG;
            else begin
               x = r.an * r.bd;
               y = r.ad * r.bn;
               rn = (r.cmd == CMD_ADD) ? x + y : x - y;
               rd = r.ad * r.bd;
               lowest_terms(rn, rd);
            end
         end
         CMD_MUL: begin
            if (adeg || bdeg) o.status = ST_DEG;
            else rat_mul(rn, rd, r.bn, r.bd);
         end
         CMD_DIV: begin
            if (adeg || bdeg) o.status = ST_DEG;
            else if (r.bn == 0) begin
               rn = 64'd1 - 64'd1;
               rd = 64'd1;
               o.status = ST_INVZ;
            end else rat_mul(rn, rd, r.bn[63] ? -r.bd : r.bd, abs_u(r.bn));
         end
         CMD_NEG: begin
            if (adeg) o.status = ST_DEG;
            else rn = -r.an;
         end
         CMD_INV: begin
            if (adeg) o.status = ST_DEG;
            else if (r.an == 0) o.status = ST_INVZ;
            else begin
               rn = r.an[63] ? -r.ad : r.ad;
               rd = abs_u(r.an);
            end
         end
         CMD_CMP, CMD_EQU: begin
            x = r.an * r.bd;
            y = r.bn * r.ad;
            if (r.cmd == CMD_CMP)
               o.order = (x == y) ? 2'b00 : ((x - y) >> 63) ? 2'b11 : 2'b01;
            else
               o.order = (x == y) ? 2'b01 : 2'b00;
            if (adeg || bdeg) o.status = ST_DEG;
         end
         CMD_RED: begin
            if (adeg) o.status = ST_DEG;
            else lowest_terms(rn, rd);
         end
         default: ;
      endcase
      // a wrapped denominator product of zero is degenerate
      if (r.cmd <= CMD_DIV && o.status == ST_OK && rd == 0) o.status = ST_DEG;
      o.num = rn;
      o.den = rd;
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h (word %0d)", what, got, want, n_checked);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            expected_q.push_back(rational_result(pending_q.pop_front()));
            n_sent++;
         end
         if ((!start || !busy) && !(start && busy)) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
               start <= 1'b1;
               req_cmd <= pending_q[0].cmd;
               req_a_num <= pending_q[0].an;
               req_a_den <= pending_q[0].ad;
               req_b_num <= pending_q[0].bn;
               req_b_den <= pending_q[0].bd;
            end else
               start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            $display("unexpected result word %h/%h", rsp_res_num, rsp_res_den);
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_res_num !== e.num) report_mismatch("res_num", rsp_res_num, e.num);
            if (rsp_res_den !== e.den) report_mismatch("res_den", rsp_res_den, e.den);
            if (rsp_order !== e.order) report_mismatch("order", rsp_order, e.order);
            if (rsp_status !== e.status) report_mismatch("status", rsp_status, e.status);
         end
         n_checked++;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // mostly small operands so gcd runs stay short, some full-width ones
   function automatic logic [63:0] rand_operand(bit den);
      logic [63:0] v;
      case ($urandom_range(9))
         0, 1: v = rand64();
         2: v = den ? 64'd0 : 64'd0;
         3: v = {1'($urandom_range(1)), 63'd0} | (den ? 64'd0 : 64'd0);
         4: v = den ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h7FFF_FFFF_FFFF_FFFF;
         5: v = {32'd0, $urandom} * 64'($urandom_range(1, 720));
         default: v = 64'($urandom_range(0, 5040));
      endcase
      if (!den && $urandom_range(1)) v = -v;
      if (den && v == 0 && $urandom_range(3) != 0) v = 64'($urandom_range(1, 360));
      return v;
   endfunction

   task automatic queue_item(logic [3:0] c, logic [63:0] an, logic [63:0] ad,
                             logic [63:0] bn, logic [63:0] bd);
      req_word_type r;
      r.cmd = c;
      r.an = an;
      r.ad = ad;
      r.bn = bn;
      r.bd = bd;
      pending_q.push_back(r);
   endtask

   localparam logic [63:0] MinNeg = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MaxPos = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

   initial begin
      int i;
      for (int c = 0; c <= 8; c++) queue_item(c[3:0], -64'd6, 64'd4, 64'd9, 64'd15);
      queue_item(CMD_ADD, 64'd1, 64'd0, 64'd1, 64'd2);
      queue_item(CMD_MUL, 64'd1, 64'd2, 64'd1, 64'd0);
      queue_item(CMD_DIV, 64'd3, 64'd5, 64'd0, 64'd7);
      queue_item(CMD_INV, 64'd0, 64'd3, 64'd1, 64'd1);
      queue_item(CMD_INV, MinNeg, AllOnes, 64'd1, 64'd1);
      queue_item(CMD_MUL, 64'd1, 64'h1_0000_0000, 64'd1, 64'h1_0000_0000);
      queue_item(CMD_RED, MinNeg, 64'd2, 64'd0, 64'd0);
      queue_item(CMD_RED, MaxPos, AllOnes, 64'd0, 64'd1);
      queue_item(CMD_CMP, 64'd1, 64'd0, 64'd2, 64'd0);
      queue_item(CMD_EQU, 64'd2, 64'd4, 64'd1, 64'd2);
      queue_item(CMD_NEG, MinNeg, 64'd1, MinNeg, AllOnes);
      queue_item(4'd9, 64'd5, 64'd0, 64'd1, 64'd1);
      queue_item(4'd15, AllOnes, AllOnes, AllOnes, AllOnes);
      queue_item(CMD_SUB, 64'd0, 64'd1, 64'd0, 64'd1);
      for (i = 0; i < 700; i++)
         queue_item(($urandom_range(19) == 0) ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(8)),
                    rand_operand(0), rand_operand(1), rand_operand(0), rand_operand(1));
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait (n_sent >= 250);
      idle_pct = 88;
      wait (n_sent >= 500);
      idle_pct = 0;
      wait (pending_q.size() == 0 && !start);
      wait (expected_q.size() == 0);
      repeat (200) @(posedge clock);
      $display("ran %0d words through all nine commands plus unused codes, %0d results checked",
               n_sent, n_checked);
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // worst case is about ~95 euclid steps per run and three runs per multiply
   initial begin
      #300000000;
      $display("timeout with %0d results outstanding", expected_q.size());
      $display("CHECKS FAILED");
      $finish;
   end
endmodule

// ===== sim.f =====
src/rna_pkg.sv
src/rna_serial.sv
src/rational_number_alu.sv
test/tb.sv
